// File: rtl/hds_pkg.sv
// Shared constants, register codes and types for the heat diffusion stencil block.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package hds_pkg;

    // Field widths
    localparam int VALUE_W    = 32;   // signed Q15.16 cell value
    localparam int WEIGHT_W   = 15;   // unsigned Q0.16 diffusion weight, held in 15 bits (below 0.5)
    localparam int SIZE_W     = 11;   // padded tile size register
    localparam int MAXCHG_W   = 31;   // running maximum of |change|
    localparam int FRAC_W     = 16;   // fraction bits of a cell value

    // Arithmetic widths
    localparam int DIFF_W     = VALUE_W + 2;        // second difference
    localparam int PROD_W     = DIFF_W + WEIGHT_W + 1; // weight times difference
    localparam int SUM_W      = VALUE_W + 3;        // old value plus rounded step
    localparam int CHG_W      = VALUE_W + 1;        // new minus old

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = WEIGHT_W;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_ROWS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_COLS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_TOP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_BOTTOM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_LEFT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_RIGHT  = 3'd7;

    // Register reset values
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_X = 15'd79;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_Y = 15'd79;
    localparam logic [SIZE_W-1:0]   RST_TILE_ROWS = 11'd8;
    localparam logic [SIZE_W-1:0]   RST_TILE_COLS = 11'd8;

    // Default line buffer depth and row limit
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    // Per-cell control carried down the pipeline
    typedef struct packed {
        logic res;        // cell produces a result
        logic upd;        // stencil applied (not a held boundary)
        logic last;       // last inner cell of the tile
        logic clr_head;   // clear running max before this cell
        logic clr_tail;   // clear running max after this cell
    } hds_flags_t;

endpackage

// File: rtl/hds_cell_if.sv
// Input channel: one padded tile cell per transaction, valid/ready handshake.
// Depends on hds_pkg for field widths.
`timescale 1ns / 1ps

interface hds_cell_if
    import hds_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  cell_value;
    logic                       frame_start;

    modport source (output valid, output cell_value, output frame_start, input ready);
    modport sink   (input valid, input cell_value, input frame_start, output ready);
endinterface

// File: rtl/hds_result_if.sv
// Output channel: one updated inner cell per transaction, valid/ready handshake.
// Depends on hds_pkg for field widths.
`timescale 1ns / 1ps

interface hds_result_if
    import hds_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  new_value;
    logic                       was_updated;
    logic [MAXCHG_W-1:0]        max_change;
    logic                       frame_last;

    modport source (output valid, output new_value, output was_updated,
                    output max_change, output frame_last, input ready);
    modport sink   (input valid, input new_value, input was_updated,
                    input max_change, input frame_last, output ready);
endinterface

// File: rtl/heat_diffusion_stencil_step.sv
// Five-point explicit heat diffusion step over one padded tile, line-buffered.
// Depends on hds_pkg, hds_cell_if and hds_result_if.
//
//   channel   | direction | transaction
//   ----------+-----------+-------------------------------------------------
//   cells     | in        | cell_value, frame_start (raster order, halo in)
//   results   | out       | new_value, was_updated, max_change, frame_last
//   cfg_*     | in        | write of register cfg_index with cfg_data
//
// One cell per cycle sustained while the output is not stalled; a result leaves the
// output register after its lower-right neighbor cell is taken and has passed every stage.
// The rate is set by the line memory, read once at acceptance and written once as the
// cell leaves stage 1, with forwarding between the two. Reset clears position, window,
// running max and pipeline valids at once; the line memory is not cleared. A stalled
// output holds its register while earlier stages keep filling empty slots behind it.
`timescale 1ns / 1ps

module heat_diffusion_stencil_step
    import hds_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    hds_cell_if.sink                cells,
    hds_result_if.source            results,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW  = $clog2(MAX_COLS);   // column position / line address
    localparam int RW  = $clog2(MAX_ROWS);   // row position
    localparam int CSW = CW + 1;             // column count
    localparam int RSW = RW + 1;             // row count
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_W - 1));

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WEIGHT_W-1:0] weight_x_reg, weight_y_reg;
    logic [SIZE_W-1:0]   tile_rows_reg, tile_cols_reg;
    logic                fixed_top_reg, fixed_bottom_reg, fixed_left_reg, fixed_right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_x_reg     <= RST_WEIGHT_X;
            weight_y_reg     <= RST_WEIGHT_Y;
            tile_rows_reg    <= RST_TILE_ROWS;
            tile_cols_reg    <= RST_TILE_COLS;
            fixed_top_reg    <= 1'b1;
            fixed_bottom_reg <= 1'b0;
            fixed_left_reg   <= 1'b1;
            fixed_right_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WEIGHT_X:     weight_x_reg     <= cfg_data;
                REG_WEIGHT_Y:     weight_y_reg     <= cfg_data;
                REG_TILE_ROWS:    tile_rows_reg    <= cfg_data[SIZE_W-1:0];
                REG_TILE_COLS:    tile_cols_reg    <= cfg_data[SIZE_W-1:0];
                REG_FIXED_TOP:    fixed_top_reg    <= cfg_data[0];
                REG_FIXED_BOTTOM: fixed_bottom_reg <= cfg_data[0];
                REG_FIXED_LEFT:   fixed_left_reg   <= cfg_data[0];
                REG_FIXED_RIGHT:  fixed_right_reg  <= cfg_data[0];
            endcase
        end
    end

    // Clamp tile size to [3, MAX]
    logic [RSW-1:0] rows_s;
    logic [CSW-1:0] cols_s;

    always_comb
    begin
        if (tile_rows_reg < SIZE_W'(3))
            rows_s = RSW'(3);
        else if (32'(tile_rows_reg) > MAX_ROWS)
            rows_s = RSW'(MAX_ROWS);
        else
            rows_s = RSW'(tile_rows_reg);

        if (tile_cols_reg < SIZE_W'(3))
            cols_s = CSW'(3);
        else if (32'(tile_cols_reg) > MAX_COLS)
            cols_s = CSW'(MAX_COLS);
        else
            cols_s = CSW'(tile_cols_reg);
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage loads when empty or when it drains
    // ------------------------------------------------------------------
    logic [6:1]  v_reg;
    logic [6:1]  adv;
    logic        out_valid_reg;
    logic        out_free;
    logic        accept;
    hds_flags_t  s1_flags_reg, s2_flags_reg, s3_flags_reg;
    hds_flags_t  s4_flags_reg, s5_flags_reg, s6_flags_reg;

    assign out_free = !out_valid_reg || results.ready;

    always_comb
    begin
        adv[6] = v_reg[6] && (!s6_flags_reg.res || out_free);
        adv[5] = v_reg[5] && (!v_reg[6] || adv[6]);
        adv[4] = v_reg[4] && (!v_reg[5] || adv[5]);
        adv[3] = v_reg[3] && (!v_reg[4] || adv[4]);
        adv[2] = v_reg[2] && (!v_reg[3] || adv[3]);
        adv[1] = v_reg[1] && (!v_reg[2] || adv[2]);
    end

    assign cells.ready = !v_reg[1] || adv[1];
    assign accept      = cells.valid && cells.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg[1] <= accept || (v_reg[1] && !adv[1]);
            v_reg[2] <= adv[1] || (v_reg[2] && !adv[2]);
            v_reg[3] <= adv[2] || (v_reg[3] && !adv[3]);
            v_reg[4] <= adv[3] || (v_reg[4] && !adv[4]);
            v_reg[5] <= adv[4] || (v_reg[5] && !adv[5]);
            v_reg[6] <= adv[5] || (v_reg[6] && !adv[6]);
        end
    end

    // ------------------------------------------------------------------
    // Accept: locate the cell in the tile and advance the position
    // ------------------------------------------------------------------
    logic [RW-1:0] row_pos_reg, row_pos_next;
    logic [CW-1:0] col_pos_reg, col_pos_next;
    logic [RW-1:0] r_cur, orow;
    logic [CW-1:0] c_cur, ocol;
    logic          col_wrap, row_wrap;
    hds_flags_t    s0_flags;

    always_comb
    begin
        r_cur = cells.frame_start ? '0 : row_pos_reg;
        c_cur = cells.frame_start ? '0 : col_pos_reg;
        orow  = r_cur - RW'(1);
        ocol  = c_cur - CW'(1);

        s0_flags.res = ({1'b0, r_cur} >= RSW'(2)) && ({1'b0, r_cur} < rows_s)
                    && ({1'b0, c_cur} >= CSW'(2)) && ({1'b0, c_cur} < cols_s);
        s0_flags.upd = !((fixed_top_reg    && {1'b0, orow} == RSW'(1))
                      || (fixed_bottom_reg && {1'b0, orow} == rows_s - RSW'(2))
                      || (fixed_left_reg   && {1'b0, ocol} == CSW'(1))
                      || (fixed_right_reg  && {1'b0, ocol} == cols_s - CSW'(2)));
        s0_flags.last = ({1'b0, orow} == rows_s - RSW'(2))
                     && ({1'b0, ocol} == cols_s - CSW'(2));

        col_wrap = ({1'b0, c_cur} + CSW'(1)) >= cols_s;
        row_wrap = ({1'b0, r_cur} + RSW'(1)) >= rows_s;

        s0_flags.clr_head = cells.frame_start;
        s0_flags.clr_tail = col_wrap && row_wrap;

        col_pos_next = col_wrap ? '0 : c_cur + CW'(1);
        if (!col_wrap)
            row_pos_next = r_cur;
        else if (row_wrap)
            row_pos_next = '0;
        else
            row_pos_next = r_cur + RW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else if (accept)
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: entry holds {upper row, middle row} for one column
    // ------------------------------------------------------------------
    logic [2*VALUE_W-1:0] line_mem [MAX_COLS];
    logic [2*VALUE_W-1:0] rd_data_reg;
    logic [2*VALUE_W-1:0] fwd_data_reg;
    logic                 fwd_hit_reg;
    logic signed [VALUE_W-1:0] s1_low_reg;
    logic [CW-1:0]             s1_col_reg;
    logic signed [VALUE_W-1:0] up_eff, mid_eff;

    // Forward the write still in flight when the same column is read
    assign {up_eff, mid_eff} = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
            line_mem[s1_col_reg] <= {mid_eff, s1_low_reg};
        if (accept)
            rd_data_reg <= line_mem[c_cur];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_hit_reg  <= v_reg[1] && (s1_col_reg == c_cur);
            fwd_data_reg <= {mid_eff, s1_low_reg};
            s1_low_reg   <= cells.cell_value;
            s1_col_reg   <= c_cur;
            s1_flags_reg <= s0_flags;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: window shift and second differences
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] win_up_reg, win_mid_reg, win_low_reg, win_left_reg;
    logic signed [DIFF_W-1:0]  dv_next, dh_next;
    logic signed [DIFF_W-1:0]  s2_dv_reg, s2_dh_reg;
    logic signed [VALUE_W-1:0] s2_old_reg;

    always_comb
    begin
        dv_next = DIFF_W'(win_up_reg) + DIFF_W'(win_low_reg)
                - {win_mid_reg[VALUE_W-1], win_mid_reg, 1'b0};
        dh_next = DIFF_W'(win_left_reg) + DIFF_W'(mid_eff)
                - {win_mid_reg[VALUE_W-1], win_mid_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_up_reg   <= '0;
            win_mid_reg  <= '0;
            win_low_reg  <= '0;
            win_left_reg <= '0;
        end
        else if (adv[1])
        begin
            win_left_reg <= win_mid_reg;
            win_up_reg   <= up_eff;
            win_mid_reg  <= mid_eff;
            win_low_reg  <= s1_low_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_dv_reg    <= dv_next;
            s2_dh_reg    <= dh_next;
            s2_old_reg   <= win_mid_reg;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: weight the differences
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]  s3_px_reg, s3_py_reg;
    logic signed [VALUE_W-1:0] s3_old_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_px_reg    <= PROD_W'($signed({1'b0, weight_x_reg})) * PROD_W'(s2_dv_reg);
            s3_py_reg    <= PROD_W'($signed({1'b0, weight_y_reg})) * PROD_W'(s2_dh_reg);
            s3_old_reg   <= s2_old_reg;
            s3_flags_reg <= s2_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum and round to Q.16, ties up
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]  step_sum;
    logic signed [DIFF_W-1:0]  s4_q_reg;
    logic signed [VALUE_W-1:0] s4_old_reg;

    assign step_sum = s3_px_reg + s3_py_reg + ROUND_HALF;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_q_reg     <= step_sum[PROD_W-1:FRAC_W];
            s4_old_reg   <= s3_old_reg;
            s4_flags_reg <= s3_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: add to old value and saturate; hold boundary cells
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]   new_sum;
    logic                      sum_fits;
    logic signed [VALUE_W-1:0] nv_next;
    logic signed [VALUE_W-1:0] s5_nv_reg, s5_old_reg;

    always_comb
    begin
        new_sum  = SUM_W'(s4_old_reg) + SUM_W'(s4_q_reg);
        sum_fits = (new_sum[SUM_W-1:VALUE_W-1] == '0)
                || (new_sum[SUM_W-1:VALUE_W-1] == '1);
        if (!s4_flags_reg.upd)
            nv_next = s4_old_reg;
        else if (sum_fits)
            nv_next = new_sum[VALUE_W-1:0];
        else if (new_sum[SUM_W-1])
            nv_next = {1'b1, {(VALUE_W-1){1'b0}}};
        else
            nv_next = {1'b0, {(VALUE_W-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_nv_reg    <= nv_next;
            s5_old_reg   <= s4_old_reg;
            s5_flags_reg <= s4_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: absolute change, saturated to 31 bits
    // ------------------------------------------------------------------
    logic signed [CHG_W-1:0] chg;
    logic [CHG_W-1:0]        chg_abs;
    logic [MAXCHG_W-1:0]     ad_next;
    logic signed [VALUE_W-1:0] s6_nv_reg;
    logic [MAXCHG_W-1:0]     s6_ad_reg;

    always_comb
    begin
        chg     = CHG_W'(s5_nv_reg) - CHG_W'(s5_old_reg);
        chg_abs = chg[CHG_W-1] ? -chg : chg;
        ad_next = (chg_abs[CHG_W-1:MAXCHG_W] != '0) ? '1 : chg_abs[MAXCHG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s6_nv_reg    <= s5_nv_reg;
            s6_ad_reg    <= ad_next;
            s6_flags_reg <= s5_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: running maximum and output register
    // ------------------------------------------------------------------
    logic [MAXCHG_W-1:0] run_max_reg, run_max_next;
    logic [MAXCHG_W-1:0] max_base, max_upd;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                out_updated_reg;
    logic [MAXCHG_W-1:0] out_max_reg;
    logic                out_last_reg;

    always_comb
    begin
        max_base = s6_flags_reg.clr_head ? '0 : run_max_reg;
        if (s6_flags_reg.res && s6_flags_reg.upd && (s6_ad_reg > max_base))
            max_upd = s6_ad_reg;
        else
            max_upd = max_base;
        run_max_next = s6_flags_reg.clr_tail ? '0 : max_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_max_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv[6])
                run_max_reg <= run_max_next;
            if (adv[6] && s6_flags_reg.res)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6] && s6_flags_reg.res)
        begin
            out_value_reg   <= s6_nv_reg;
            out_updated_reg <= s6_flags_reg.upd;
            out_max_reg     <= max_upd;
            out_last_reg    <= s6_flags_reg.last;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.new_value   = out_value_reg;
    assign results.was_updated = out_updated_reg;
    assign results.max_change  = out_max_reg;
    assign results.frame_last  = out_last_reg;

endmodule

// File: tb/sv/heat_diffusion_stencil_step_test.sv
// Self-checking testbench for heat_diffusion_stencil_step: streams padded tiles in raster order
// and checks every inner cell update against a local line-buffered stencil model.
// Depends on hds_pkg, hds_cell_if, hds_result_if and the heat_diffusion_stencil_step RTL.
`timescale 1ns / 1ps

module heat_diffusion_stencil_step_test;
    import hds_pkg::*;

    localparam int     MAX_COLS      = DEF_MAX_COLS;
    localparam int     MAX_ROWS      = DEF_MAX_ROWS;
    localparam int     RANDOM_ITEMS  = 800;
    localparam int     SETTLE_CYCLES = 20;     // pipeline is 7 deep; leave margin
    localparam int     MAX_GAP       = 19;
    localparam int     MAX_REPORTS   = 10;
    localparam longint CYCLE_LIMIT   = 2000000;
    localparam longint VALUE_MAX     = 64'sd2147483647;
    localparam longint VALUE_MIN     = -64'sd2147483648;

    typedef logic signed [VALUE_W-1:0] temp_t;

    localparam temp_t TEMP_MAX = 32'sh7FFFFFFF;
    localparam temp_t TEMP_MIN = 32'sh80000000;

    typedef struct packed {
        temp_t               new_value;
        logic                was_updated;
        logic [MAXCHG_W-1:0] max_change;
        logic                frame_last;
    } stencil_result_t;

    typedef enum logic {STEP_CFG, STEP_CELL} step_kind_t;

    typedef struct {
        step_kind_t           kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [VALUE_W-1:0]   value;
        logic                 start;
        logic                 typed;
        stencil_result_t      want;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hds_cell_if   cell_ch ();
    hds_result_if result_ch ();

    heat_diffusion_stencil_step uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cells     (cell_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of the configuration registers
    logic [WEIGHT_W-1:0] wt_x        = RST_WEIGHT_X;
    logic [WEIGHT_W-1:0] wt_y        = RST_WEIGHT_Y;
    logic [SIZE_W-1:0]   rows_reg    = RST_TILE_ROWS;
    logic [SIZE_W-1:0]   cols_reg    = RST_TILE_COLS;
    logic                hold_top    = 1'b1;
    logic                hold_bottom = 1'b0;
    logic                hold_left   = 1'b1;
    logic                hold_right  = 1'b0;

    // Stencil state: two line buffers, a 3x2 window, position and running max
    temp_t               upper_ln [MAX_COLS] = '{default: '0};
    temp_t               middle_ln [MAX_COLS] = '{default: '0};
    temp_t               win [6] = '{default: '0};
    int                  row_pos = 0;
    int                  col_pos = 0;
    logic [MAXCHG_W-1:0] peak_change = '0;

    stencil_result_t due_updates [$];
    directed_row_t   directed_rows [$];
    int              mismatches = 0;
    int              cells_fed = 0;
    longint          cycle_count = 0;
    bit              feed_calm = 1'b0;
    bit              drain_calm = 1'b0;

    always #1 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("heat_diffusion_stencil_step test failed");
            $finish;
        end
    end

    function automatic int clamp_dim(input logic [SIZE_W-1:0] v, input int hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return int'(v);
    endfunction

    function automatic int tile_cells();
        return clamp_dim(rows_reg, MAX_ROWS) * clamp_dim(cols_reg, MAX_COLS);
    endfunction

    // Take one padded cell; return 1 and the inner cell update when one completes
    function automatic bit advance_stencil(input temp_t low, input logic start,
                                           output stencil_result_t res);
        int                  nrows;
        int                  ncols;
        int                  r;
        int                  c;
        int                  orow;
        int                  ocol;
        temp_t               up;
        temp_t               mid;
        temp_t               nv;
        longint              old;
        longint              dv;
        longint              dh;
        longint              acc;
        longint              sum;
        longint              d;
        logic [MAXCHG_W-1:0] ad;
        logic                held;
        bit                  hit;

        res   = '0;
        hit   = 1'b0;
        nrows = clamp_dim(rows_reg, MAX_ROWS);
        ncols = clamp_dim(cols_reg, MAX_COLS);
        if (start)
        begin
            row_pos     = 0;
            col_pos     = 0;
            peak_change = '0;
        end
        r = row_pos;
        c = (col_pos >= MAX_COLS) ? MAX_COLS - 1 : col_pos;
        up  = upper_ln[c];
        mid = middle_ln[c];

        // Inner cell (r-1, c-1) is complete once its lower-right neighbor arrives
        if (r >= 2 && r < nrows && c >= 2 && c < ncols)
        begin
            orow = r - 1;
            ocol = c - 1;
            old  = longint'(win[1]);
            held = (hold_top && orow == 1) || (hold_bottom && orow == nrows - 2) ||
                   (hold_left && ocol == 1) || (hold_right && ocol == ncols - 2);
            if (held)
                nv = win[1];
            else
            begin
                dv  = longint'(win[0]) + longint'(win[2]) - 2 * old;
                dh  = longint'(win[4]) + longint'(mid) - 2 * old;
                acc = longint'(wt_x) * dv + longint'(wt_y) * dh + 32768;
                sum = old + (acc >>> FRAC_W);
                if (sum > VALUE_MAX)
                    nv = TEMP_MAX;
                else if (sum < VALUE_MIN)
                    nv = TEMP_MIN;
                else
                    nv = temp_t'(sum);
                d = longint'(nv) - old;
                if (d < 0)
                    d = -d;
                ad = (d > 64'sh7FFFFFFF) ? {MAXCHG_W{1'b1}} : d[MAXCHG_W-1:0];
                if (ad > peak_change)
                    peak_change = ad;
            end
            res.new_value   = nv;
            res.was_updated = !held;
            res.max_change  = peak_change;
            res.frame_last  = (orow == nrows - 2) && (ocol == ncols - 2);
            hit = 1'b1;
        end

        // Shift the window and update the line buffers
        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = up;
        win[1] = mid;
        win[2] = low;
        upper_ln[c]  = mid;
        middle_ln[c] = low;

        // Advance the raster position, wrapping at the end of the tile
        if (col_pos + 1 >= ncols)
        begin
            col_pos = 0;
            if (row_pos + 1 >= nrows)
            begin
                row_pos     = 0;
                peak_change = '0;
            end
            else
                row_pos++;
        end
        else
            col_pos++;
        return hit;
    endfunction

    task automatic log_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Write one register; the block must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_WEIGHT_X:     wt_x        = data[WEIGHT_W-1:0];
            REG_WEIGHT_Y:     wt_y        = data[WEIGHT_W-1:0];
            REG_TILE_ROWS:    rows_reg    = data[SIZE_W-1:0];
            REG_TILE_COLS:    cols_reg    = data[SIZE_W-1:0];
            REG_FIXED_TOP:    hold_top    = data[0];
            REG_FIXED_BOTTOM: hold_bottom = data[0];
            REG_FIXED_LEFT:   hold_left   = data[0];
            REG_FIXED_RIGHT:  hold_right  = data[0];
        endcase
    endtask

    // Hold off the sender until every update is back and the pipeline is empty
    task automatic drain_pipeline();
        cell_ch.valid = 1'b0;
        while (due_updates.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Send one cell transaction and queue the update it completes
    task automatic feed_cell(input temp_t value, input logic start, input logic typed,
                             input stencil_result_t want);
        stencil_result_t upd;
        int              gap;
        bit              hit;

        gap = feed_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            cell_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cell_ch.valid       = 1'b1;
        cell_ch.cell_value  = value;
        cell_ch.frame_start = start;
        do
            @(posedge clk);
        while (!cell_ch.ready);
        hit = advance_stencil(value, start, upd);
        if (typed)
            due_updates.push_back(want);
        else if (hit)
            due_updates.push_back(upd);
        cells_fed++;
        @(negedge clk);
    endtask

    function automatic temp_t draw_temperature(input int mode);
        case (mode)
            0: return temp_t'($urandom);
            1: return temp_t'($urandom_range(0, 2097152)) - 32'sd1048576;
            default:
                case ($urandom_range(0, 4))
                    0:       return TEMP_MAX;
                    1:       return TEMP_MIN;
                    2:       return '0;
                    3:       return -32'sd1;
                    default: return temp_t'($urandom);
                endcase
        endcase
    endfunction

    function automatic logic [31:0] draw_weight();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 32767;
            2:       return $urandom_range(0, 32767);
            default: return $urandom_range(0, 2000);
        endcase
    endfunction

    // Send a run of cells; restart the frame on the first one unless resuming
    task automatic send_frame(input int ncells, input int mode, input bit noisy,
                              input bit resume);
        logic start;

        for (int i = 0; i < ncells; i++)
        begin
            if (i == 0 && !resume)
                start = (row_pos == 0 && col_pos == 0) ? ($urandom_range(0, 1) == 1) : 1'b1;
            else
                start = noisy && ($urandom_range(0, 3) == 0);
            feed_cell(draw_temperature(mode), start, 1'b0, '0);
        end
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        directed_row_t row;

        row         = '{kind: STEP_CFG, default: '0};
        row.reg_idx = idx;
        row.value   = data;
        directed_rows.push_back(row);
    endtask

    task automatic add_cell(input temp_t value, input logic start, input logic typed,
                            input stencil_result_t want);
        directed_row_t row;

        row       = '{kind: STEP_CELL, default: '0};
        row.value = value;
        row.start = start;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Result side: random stalls, check each transaction against the oldest expectation
    initial
    begin
        stencil_result_t got;
        stencil_result_t want;
        int              stall;

        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = drain_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            got.new_value   = result_ch.new_value;
            got.was_updated = result_ch.was_updated;
            got.max_change  = result_ch.max_change;
            got.frame_last  = result_ch.frame_last;
            if (due_updates.size() == 0)
                log_failure($sformatf("unexpected update: new_value=%h was_updated=%b %s%h %s%b",
                    got.new_value, got.was_updated, "max_change=", got.max_change,
                    "frame_last=", got.frame_last));
            else
            begin
                want = due_updates.pop_front();
                if (got !== want)
                    log_failure($sformatf({"update mismatch: expected %h/%b/%h/%b, ",
                        "got %h/%b/%h/%b (new_value/was_updated/max_change/frame_last)"},
                        want.new_value, want.was_updated, want.max_change, want.frame_last,
                        got.new_value, got.was_updated, got.max_change, got.frame_last));
            end
            @(negedge clk);
        end
    end

    // Stimulus
    initial
    begin
        stencil_result_t want;
        int              random_base;
        int              mode;
        int              kind;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        cell_ch.valid       = 1'b0;
        cell_ch.cell_value  = '0;
        cell_ch.frame_start = 1'b0;
        result_ch.ready     = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: smallest tile, single inner cell held by the top and left sides
        add_cfg(REG_TILE_ROWS, 3);
        add_cfg(REG_TILE_COLS, 3);
        for (int i = 0; i < 9; i++)
        begin
            want = '{new_value: 32'sh12345678, was_updated: 1'b0, max_change: '0,
                     frame_last: 1'b1};
            add_cell((i == 4) ? 32'sh12345678 : temp_t'(i << FRAC_W), i == 0, i == 8, want);
        end

        // Directed: sizes below range clamp to 3, full weights drive the center to saturation;
        // the frame follows the previous one without a frame start
        add_cfg(REG_FIXED_TOP, 0);
        add_cfg(REG_FIXED_LEFT, 0);
        add_cfg(REG_WEIGHT_X, 32767);
        add_cfg(REG_WEIGHT_Y, 32767);
        add_cfg(REG_TILE_ROWS, 0);
        add_cfg(REG_TILE_COLS, 2);
        for (int i = 0; i < 9; i++)
        begin
            want = '{new_value: TEMP_MIN, was_updated: 1'b1, max_change: {MAXCHG_W{1'b1}},
                     frame_last: 1'b1};
            add_cell((i == 4) ? TEMP_MAX : TEMP_MIN, 1'b0, i == 8, want);
        end

        // Directed: bottom and right sides both hold the single inner cell
        add_cfg(REG_FIXED_BOTTOM, 1);
        add_cfg(REG_FIXED_RIGHT, 1);
        for (int i = 0; i < 9; i++)
        begin
            want = '{new_value: -32'sd1, was_updated: 1'b0, max_change: '0, frame_last: 1'b1};
            add_cell((i == 4) ? -32'sd1 : ((i % 2) ? TEMP_MAX : 32'sd0), i == 0, i == 8, want);
        end

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == STEP_CFG)
            begin
                drain_pipeline();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end
            else
                feed_cell(directed_rows[i].value, directed_rows[i].start,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // Oversized tiles: height, then width, above range; send the opening part of each
        drain_pipeline();
        feed_calm  = 1'b1;
        drain_calm = 1'b1;
        write_reg(REG_TILE_ROWS, 2047);
        write_reg(REG_TILE_COLS, 3);
        send_frame(120, 0, 1'b0, 1'b0);
        drain_pipeline();
        write_reg(REG_TILE_ROWS, 3);
        write_reg(REG_TILE_COLS, 2047);
        send_frame(64, 1, 1'b0, 1'b0);

        // Shrink width, then height, in the middle of a frame
        drain_pipeline();
        feed_calm  = 1'b0;
        drain_calm = 1'b0;
        write_reg(REG_TILE_ROWS, 10);
        write_reg(REG_TILE_COLS, 10);
        write_reg(REG_WEIGHT_X, 1500);
        write_reg(REG_WEIGHT_Y, 900);
        send_frame(57, 1, 1'b0, 1'b0);
        drain_pipeline();
        write_reg(REG_TILE_COLS, 5);
        send_frame(15, 1, 1'b0, 1'b1);
        drain_pipeline();
        write_reg(REG_TILE_ROWS, 4);
        send_frame(5 + tile_cells(), 1, 1'b0, 1'b1);

        // Random phases: new settings, then well-formed, cut-short and noisy frames
        random_base = cells_fed;
        while (cells_fed - random_base < RANDOM_ITEMS)
        begin
            drain_pipeline();
            write_reg(REG_WEIGHT_X, draw_weight());
            write_reg(REG_WEIGHT_Y, draw_weight());
            write_reg(REG_TILE_ROWS, $urandom_range(0, 10));
            write_reg(REG_TILE_COLS, $urandom_range(0, 10));
            write_reg(REG_FIXED_TOP, $urandom_range(0, 1));
            write_reg(REG_FIXED_BOTTOM, $urandom_range(0, 1));
            write_reg(REG_FIXED_LEFT, $urandom_range(0, 1));
            write_reg(REG_FIXED_RIGHT, $urandom_range(0, 1));
            feed_calm  = ($urandom_range(0, 3) == 0);
            drain_calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 7) == 0)
                    drain_pipeline();
                mode = $urandom_range(0, 2);
                kind = $urandom_range(0, 9);
                if (kind <= 6)
                    send_frame(tile_cells(), mode, 1'b0, 1'b0);
                else if (kind <= 8)
                    send_frame($urandom_range(1, tile_cells() - 1), mode, 1'b0, 1'b0);
                else
                    send_frame($urandom_range(1, 12), mode, 1'b1, 1'b0);
            end
        end

        // Wait out the remaining updates
        cell_ch.valid = 1'b0;
        while (due_updates.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("heat_diffusion_stencil_step test passed");
        else
            $display("heat_diffusion_stencil_step test failed");
        $finish;
    end

endmodule

// File: heat_diffusion_stencil_step.f
rtl/hds_pkg.sv
rtl/hds_cell_if.sv
rtl/hds_result_if.sv
rtl/heat_diffusion_stencil_step.sv
tb/sv/heat_diffusion_stencil_step_test.sv
